// ===== rtl/bdm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the banked data memory unit
package bdm_pkg;

    localparam int ADDR_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int REQ_W      = 3;
    localparam int PTR_W      = 2;
    localparam int MAIN_DEPTH = 512;
    localparam int DISP_DEPTH = 384;
    localparam int SFR_DEPTH  = 128;
    localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
    localparam int DISP_AW    = $clog2(DISP_DEPTH);
    localparam int SFR_AW     = $clog2(SFR_DEPTH);
    localparam int CLR_W      = MAIN_AW;

    // first display address; the register file sits between 0x100 and this
    localparam logic [ADDR_W-1:0] DISPLAY_BASE = 9'd384;
    localparam logic [ADDR_W-1:0] ADDR_MASK    = 9'h1FF;
    localparam logic [ADDR_W-1:0] SFR_LOW      = 9'h100;
    localparam logic [1:0]        XBNK_MAX     = 2'h2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INDIR   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP     = 3'd4;

    // register indexes inside the register file
    localparam logic [SFR_AW-1:0] R_ACC   = 7'h00;
    localparam logic [SFR_AW-1:0] R_PSW   = 7'h01;
    localparam logic [SFR_AW-1:0] R_SP    = 7'h06;
    localparam logic [SFR_AW-1:0] R_T0CON = 7'h10;
    localparam logic [SFR_AW-1:0] R_T0PRR = 7'h11;
    localparam logic [SFR_AW-1:0] R_T0L   = 7'h12;
    localparam logic [SFR_AW-1:0] R_T0LR  = 7'h13;
    localparam logic [SFR_AW-1:0] R_T0H   = 7'h14;
    localparam logic [SFR_AW-1:0] R_T0HR  = 7'h15;
    localparam logic [SFR_AW-1:0] R_T1CNT = 7'h18;
    localparam logic [SFR_AW-1:0] R_T1LC  = 7'h1A;
    localparam logic [SFR_AW-1:0] R_T1LR  = 7'h1B;
    localparam logic [SFR_AW-1:0] R_T1HC  = 7'h1C;
    localparam logic [SFR_AW-1:0] R_T1HR  = 7'h1D;
    localparam logic [SFR_AW-1:0] R_XBNK  = 7'h25;
    localparam logic [SFR_AW-1:0] R_P3    = 7'h4C;
    localparam logic [SFR_AW-1:0] R_VTRBF = 7'h66;
    localparam logic [SFR_AW-1:0] R_BTCR  = 7'h7F;

    // status word bit positions
    localparam int PSW_PTRBK_HI = 4;
    localparam int PSW_PTRBK_LO = 3;
    localparam int PSW_RAM_SEL  = 1;
    localparam int PSW_P        = 0;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] mem_addr;
        logic [BYTE_W-1:0] write_byte;
        logic [PTR_W-1:0]  pointer_sel;
        logic [BYTE_W-1:0] button_levels;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [ADDR_W-1:0] resolved_addr;
        logic              display_dirty;
        logic              peripheral_hit;
        logic              retune_audio;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic             clr;
        logic [CLR_W-1:0] clr_idx;
        logic             latch;
        logic             exec;
    } t_cmd;

endpackage

// ===== rtl/bdm_ctrl.sv =====
`timescale 1ns / 1ps
// controller: clearing sweep after reset and per-request sequencing
module bdm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output bdm_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;
    localparam logic [bdm_pkg::CLR_W-1:0] CLR_LAST = bdm_pkg::CLR_W'(bdm_pkg::MAIN_DEPTH - 1);

    logic [1:0]                r_state, n_state;
    logic [bdm_pkg::CLR_W-1:0] r_clr_idx, n_clr_idx;
    logic                      accept;

    assign o_busy = (r_state == ST_CLEAR) || (r_state == ST_EXEC);
    assign accept = i_start && !o_busy;
    assign o_done = (r_state == ST_DONE);

    // commands to the datapath
    assign o_cmd.clr     = (r_state == ST_CLEAR);
    assign o_cmd.clr_idx = r_clr_idx;
    assign o_cmd.latch   = accept;
    assign o_cmd.exec    = (r_state == ST_EXEC);

    // next state
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = accept ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

endmodule

// ===== rtl/bdm_dp.sv =====
`timescale 1ns / 1ps
// datapath: ram banks, register file, display ram, key registers, result select
module bdm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bdm_pkg::t_cmd i_cmd,
    input  bdm_pkg::t_req i_req,
    output bdm_pkg::t_res o_result
);

    localparam int BW = bdm_pkg::BYTE_W;
    localparam int AW = bdm_pkg::ADDR_W;

    // read source codes
    localparam logic [1:0] SRC_MAIN   = 2'd0;
    localparam logic [1:0] SRC_DISP   = 2'd1;
    localparam logic [1:0] SRC_SFR    = 2'd2;
    localparam logic [1:0] SRC_DIRECT = 2'd3;

    logic [BW-1:0] main_mem [bdm_pkg::MAIN_DEPTH];
    logic [BW-1:0] disp_mem [bdm_pkg::DISP_DEPTH];
    logic [BW-1:0] sfr_mem  [bdm_pkg::SFR_DEPTH];

    bdm_pkg::t_req r_req;
    logic [BW-1:0] r_acc, n_acc;
    logic [BW-1:0] r_psw, n_psw;
    logic [BW-1:0] r_sp, n_sp;
    logic [BW-1:0] r_xbnk, n_xbnk;

    logic [BW-1:0] r_main_q, r_disp_q, r_sfr_q;
    logic [BW-1:0] r_direct, n_direct;
    logic [1:0]    r_src, n_src;
    logic          r_rd_en, n_rd_en;
    logic          r_res_en, n_res_en;
    logic          r_ptr_hi, n_ptr_hi;
    logic          r_dirty, n_dirty;
    logic          r_hit, n_hit;
    logic          r_retune, n_retune;

    logic [bdm_pkg::REQ_W-1:0]    rt;
    logic [AW-1:0]                a;
    logic [BW-1:0]                wb;
    logic                         is_low, is_disp, is_sfr;
    logic [bdm_pkg::SFR_AW-1:0]   sfr_idx;
    logic                         bank;
    logic [1:0]                   xb;
    logic [AW-1:0]                disp_off;
    logic [BW-1:0]                psw_rd;
    logic [BW-1:0]                sp_inc, sp_dec;

    logic                          main_we, disp_we, sfr_we;
    logic [bdm_pkg::MAIN_AW-1:0]   main_addr;
    logic [bdm_pkg::DISP_AW-1:0]   disp_addr;
    logic [bdm_pkg::SFR_AW-1:0]    sfr_addr;
    logic [BW-1:0]                 main_wd, disp_wd, sfr_wd;
    logic [BW-1:0]                 rd_val;

    // address decode of the held request
    assign rt       = r_req.req_type;
    assign a        = r_req.mem_addr & bdm_pkg::ADDR_MASK;
    assign wb       = r_req.write_byte;
    assign is_low   = (a < bdm_pkg::SFR_LOW);
    assign is_disp  = (a >= bdm_pkg::DISPLAY_BASE);
    assign is_sfr   = !is_low && !is_disp;
    assign sfr_idx  = a[bdm_pkg::SFR_AW-1:0];
    assign bank     = r_psw[bdm_pkg::PSW_RAM_SEL];
    assign xb       = (r_xbnk[1:0] > bdm_pkg::XBNK_MAX) ? bdm_pkg::XBNK_MAX : r_xbnk[1:0];
    assign disp_off = a - bdm_pkg::DISPLAY_BASE;
    assign psw_rd   = {r_psw[BW-1:1], ^r_acc};
    assign sp_inc   = r_sp + 1'b1;
    assign sp_dec   = r_sp - 1'b1;

    // memory port steering
    always_comb begin
        main_we   = 1'b0;
        disp_we   = 1'b0;
        sfr_we    = 1'b0;
        main_wd   = wb;
        disp_wd   = wb;
        sfr_wd    = wb;
        disp_addr = {xb, disp_off[6:0]};
        sfr_addr  = sfr_idx;
        main_addr = {bank, a[7:0]};
        if (rt == bdm_pkg::REQ_INDIR) begin
            main_addr = {bank, 4'b0, r_psw[bdm_pkg::PSW_PTRBK_HI],
                         r_psw[bdm_pkg::PSW_PTRBK_LO], r_req.pointer_sel};
        end else if (rt == bdm_pkg::REQ_PUSH) begin
            main_addr = {1'b0, sp_inc};
        end else if (rt == bdm_pkg::REQ_POP) begin
            main_addr = {1'b0, r_sp};
        end
        if (sfr_idx == bdm_pkg::R_PSW) begin
            sfr_wd = {wb[BW-1:1], r_psw[bdm_pkg::PSW_P]};
        end
        if (i_cmd.exec) begin
            main_we = ((rt == bdm_pkg::REQ_WRITE) && is_low) || (rt == bdm_pkg::REQ_PUSH);
            disp_we = (rt == bdm_pkg::REQ_WRITE) && is_disp;
            sfr_we  = (rt == bdm_pkg::REQ_WRITE) && is_sfr;
        end
        // clearing sweep after reset
        if (i_cmd.clr) begin
            main_we   = 1'b1;
            main_addr = i_cmd.clr_idx;
            main_wd   = '0;
            disp_we   = (i_cmd.clr_idx < bdm_pkg::CLR_W'(bdm_pkg::DISP_DEPTH));
            disp_addr = i_cmd.clr_idx;
            disp_wd   = '0;
            sfr_we    = (i_cmd.clr_idx < bdm_pkg::CLR_W'(bdm_pkg::SFR_DEPTH));
            sfr_addr  = i_cmd.clr_idx[bdm_pkg::SFR_AW-1:0];
            sfr_wd    = '0;
        end
    end

    // memories with registered read data
    always_ff @(posedge i_clk) begin
        if (main_we) begin
            main_mem[main_addr] <= main_wd;
        end
        r_main_q <= main_mem[main_addr];
    end

    always_ff @(posedge i_clk) begin
        if (disp_we) begin
            disp_mem[disp_addr] <= disp_wd;
        end
        r_disp_q <= disp_mem[disp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sfr_we) begin
            sfr_mem[sfr_addr] <= sfr_wd;
        end
        r_sfr_q <= sfr_mem[sfr_addr];
    end

    // key registers, flags and read source for the request in flight
    always_comb begin
        n_acc    = r_acc;
        n_psw    = r_psw;
        n_sp     = r_sp;
        n_xbnk   = r_xbnk;
        n_src    = r_src;
        n_direct = r_direct;
        n_rd_en  = r_rd_en;
        n_res_en = r_res_en;
        n_ptr_hi = r_ptr_hi;
        n_dirty  = r_dirty;
        n_hit    = r_hit;
        n_retune = r_retune;
        if (i_cmd.exec) begin
            n_src    = SRC_MAIN;
            n_direct = '0;
            n_rd_en  = 1'b0;
            n_res_en = 1'b0;
            n_ptr_hi = r_req.pointer_sel[1];
            n_dirty  = 1'b0;
            n_hit    = 1'b0;
            n_retune = 1'b0;
            unique case (rt)
                bdm_pkg::REQ_READ: begin
                    n_rd_en = 1'b1;
                    if (is_low) begin
                        n_src = SRC_MAIN;
                    end else if (is_disp) begin
                        n_src = SRC_DISP;
                    end else begin
                        n_src = SRC_DIRECT;
                        n_hit = (sfr_idx == bdm_pkg::R_T0L) || (sfr_idx == bdm_pkg::R_T0H) ||
                                (sfr_idx == bdm_pkg::R_T1LR) ||
                                (sfr_idx == bdm_pkg::R_T1HR) ||
                                (sfr_idx == bdm_pkg::R_VTRBF);
                        if (sfr_idx == bdm_pkg::R_P3) begin
                            n_direct = ~r_req.button_levels;
                        end else if (sfr_idx == bdm_pkg::R_PSW) begin
                            n_direct = psw_rd;
                            n_psw    = psw_rd;
                        end else if (sfr_idx == bdm_pkg::R_ACC) begin
                            n_direct = r_acc;
                        end else if (sfr_idx == bdm_pkg::R_SP) begin
                            n_direct = r_sp;
                        end else if (sfr_idx == bdm_pkg::R_XBNK) begin
                            n_direct = r_xbnk;
                        end else begin
                            n_src = SRC_SFR;
                        end
                    end
                end
                bdm_pkg::REQ_WRITE: begin
                    if (is_disp) begin
                        n_dirty = 1'b1;
                    end else if (is_sfr) begin
                        n_hit = (sfr_idx == bdm_pkg::R_T0CON) ||
                                (sfr_idx == bdm_pkg::R_T0PRR) ||
                                (sfr_idx == bdm_pkg::R_T0LR) ||
                                (sfr_idx == bdm_pkg::R_T0HR) ||
                                (sfr_idx == bdm_pkg::R_T1CNT) ||
                                (sfr_idx == bdm_pkg::R_T1LC) ||
                                (sfr_idx == bdm_pkg::R_T1HC) ||
                                (sfr_idx == bdm_pkg::R_T1LR) ||
                                (sfr_idx == bdm_pkg::R_T1HR) ||
                                (sfr_idx == bdm_pkg::R_BTCR) ||
                                (sfr_idx == bdm_pkg::R_VTRBF);
                        n_retune = (sfr_idx == bdm_pkg::R_T1CNT) ||
                                   (sfr_idx == bdm_pkg::R_T1LR) ||
                                   (sfr_idx == bdm_pkg::R_T1LC);
                        if (sfr_idx == bdm_pkg::R_ACC) begin
                            n_acc = wb;
                        end
                        if (sfr_idx == bdm_pkg::R_PSW) begin
                            n_psw = sfr_wd;
                        end
                        if (sfr_idx == bdm_pkg::R_SP) begin
                            n_sp = wb;
                        end
                        if (sfr_idx == bdm_pkg::R_XBNK) begin
                            n_xbnk = wb;
                        end
                    end
                end
                bdm_pkg::REQ_INDIR: begin
                    n_res_en = 1'b1;
                end
                bdm_pkg::REQ_PUSH: begin
                    n_sp = sp_inc;
                end
                bdm_pkg::REQ_POP: begin
                    n_rd_en = 1'b1;
                    n_sp    = sp_dec;
                end
                default: begin
                    n_src = SRC_MAIN;
                end
            endcase
        end
    end

    // request hold and result state
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        r_src    <= n_src;
        r_direct <= n_direct;
        r_ptr_hi <= n_ptr_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_psw    <= '0;
            r_sp     <= '0;
            r_xbnk   <= '0;
            r_rd_en  <= 1'b0;
            r_res_en <= 1'b0;
            r_dirty  <= 1'b0;
            r_hit    <= 1'b0;
            r_retune <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_psw    <= n_psw;
            r_sp     <= n_sp;
            r_xbnk   <= n_xbnk;
            r_rd_en  <= n_rd_en;
            r_res_en <= n_res_en;
            r_dirty  <= n_dirty;
            r_hit    <= n_hit;
            r_retune <= n_retune;
        end
    end

    // result select
    always_comb begin
        unique case (r_src)
            SRC_MAIN:   rd_val = r_main_q;
            SRC_DISP:   rd_val = r_disp_q;
            SRC_SFR:    rd_val = r_sfr_q;
            SRC_DIRECT: rd_val = r_direct;
            default:    rd_val = '0;
        endcase
    end

    assign o_result.read_byte      = r_rd_en ? rd_val : '0;
    assign o_result.resolved_addr  = r_res_en ? {r_ptr_hi, rd_val} : '0;
    assign o_result.display_dirty  = r_dirty;
    assign o_result.peripheral_hit = r_hit;
    assign o_result.retune_audio   = r_retune;

endmodule

// ===== rtl/banked_data_memory_sfr_stack.sv =====
`timescale 1ns / 1ps
// top level of the banked data memory unit with register file and stack
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------
//  request   | start in, busy out      | i_req (bdm_pkg::t_req)
//  result    | o_done strobe out       | o_result (bdm_pkg::t_res)
//
// each request passes through a memory access state, then the result state;
// a new request may be taken in the result state.
// the single-port memories set this order: access, then registered read data.
// after reset the unit sweeps the memories to zero, busy high.
// o_done is high for one cycle per request; the receiver cannot stall it.
module banked_data_memory_sfr_stack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bdm_pkg::t_req i_req,
    output logic          o_done,
    output bdm_pkg::t_res o_result
);

    bdm_pkg::t_cmd cmd;

    bdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    bdm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule

// ===== rtl/bdm_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the banked data memory unit, with its bind
module bdm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input bdm_pkg::t_req i_req,
    input logic          o_done,
    input bdm_pkg::t_res o_result
);

    // an accepted request gets its result after the exec state, in the done state
    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result missing after accepted request");

    // no result without a request accepted ahead of its exec state
    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without request");

    // the unit is busy in the cycle after accepting
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // only read and pop return a data byte
    a_read_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_req.req_type, 2) != bdm_pkg::REQ_READ) &&
         ($past(i_req.req_type, 2) != bdm_pkg::REQ_POP)) |-> (o_result.read_byte == '0))
        else $error("read byte set for a non-read request");

endmodule

bind banked_data_memory_sfr_stack bdm_checker u_bdm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the banked data memory unit with register file and stack
module tb;

    localparam int LIMIT_CYCLES = 500000;
    localparam int N_RANDOM     = 2000;

    // one pending request with the idle cycles in front of it
    typedef struct {
        bdm_pkg::t_req rq;
        int            idle;
        bit            settle;
    } t_access;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    bdm_pkg::t_req i_req   = '0;
    logic          o_done;
    bdm_pkg::t_res o_result;

    // shadow copies of the three stores
    logic [bdm_pkg::BYTE_W-1:0] ram_img  [bdm_pkg::MAIN_DEPTH];
    logic [bdm_pkg::BYTE_W-1:0] sfr_img  [bdm_pkg::SFR_DEPTH];
    logic [bdm_pkg::BYTE_W-1:0] disp_img [bdm_pkg::DISP_DEPTH];

    t_access       access_q[$];
    bdm_pkg::t_res access_due[$];
    int      n_total = 0;
    int      n_taken = 0;
    int      n_bad   = 0;
    int      n_cycles = 0;
    bit      calm    = 1'b0;

    logic [bdm_pkg::SFR_AW-1:0] named_regs [18] = '{bdm_pkg::R_ACC, bdm_pkg::R_PSW,
        bdm_pkg::R_SP, bdm_pkg::R_T0CON, bdm_pkg::R_T0PRR, bdm_pkg::R_T0L,
        bdm_pkg::R_T0LR, bdm_pkg::R_T0H, bdm_pkg::R_T0HR, bdm_pkg::R_T1CNT,
        bdm_pkg::R_T1LC, bdm_pkg::R_T1LR, bdm_pkg::R_T1HC, bdm_pkg::R_T1HR,
        bdm_pkg::R_XBNK, bdm_pkg::R_P3, bdm_pkg::R_VTRBF, bdm_pkg::R_BTCR};

    banked_data_memory_sfr_stack dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // ram bank picked by the status word
    function automatic logic cur_bank();
        return sfr_img[bdm_pkg::R_PSW][bdm_pkg::PSW_RAM_SEL];
    endfunction

    // display index from bank register, clamped, and low offset bits
    function automatic int disp_slot(logic [bdm_pkg::ADDR_W-1:0] a);
        logic [1:0] b;
        logic [bdm_pkg::ADDR_W-1:0] off;
        b = sfr_img[bdm_pkg::R_XBNK][1:0];
        if (b > bdm_pkg::XBNK_MAX) b = bdm_pkg::XBNK_MAX;
        off = a - bdm_pkg::DISPLAY_BASE;
        return int'(b) * 128 + int'(off[6:0]);
    endfunction

    // expected result of one request, shadow stores updated on the way
    function automatic bdm_pkg::t_res access_model(bdm_pkg::t_req q);
        bdm_pkg::t_res r;
        logic [bdm_pkg::SFR_AW-1:0] ri;
        logic [bdm_pkg::BYTE_W-1:0] wb;
        logic [bdm_pkg::BYTE_W-1:0] sp;
        logic [3:0] slot;
        r  = '0;
        wb = q.write_byte;
        ri = q.mem_addr[bdm_pkg::SFR_AW-1:0];
        case (q.req_type)
            bdm_pkg::REQ_READ: begin
                if (q.mem_addr < bdm_pkg::SFR_LOW) begin
                    r.read_byte = ram_img[{cur_bank(), q.mem_addr[7:0]}];
                end else if (q.mem_addr >= bdm_pkg::DISPLAY_BASE) begin
                    r.read_byte = disp_img[disp_slot(q.mem_addr)];
                end else begin
                    // status read refreshes the parity bit first
                    if (ri == bdm_pkg::R_PSW)
                        sfr_img[bdm_pkg::R_PSW][bdm_pkg::PSW_P] = ^sfr_img[bdm_pkg::R_ACC];
                    r.peripheral_hit = ri inside {bdm_pkg::R_T0L, bdm_pkg::R_T0H,
                        bdm_pkg::R_T1LR, bdm_pkg::R_T1HR, bdm_pkg::R_VTRBF};
                    r.read_byte = (ri == bdm_pkg::R_P3) ? ~q.button_levels : sfr_img[ri];
                end
            end
            bdm_pkg::REQ_WRITE: begin
                if (q.mem_addr < bdm_pkg::SFR_LOW) begin
                    ram_img[{cur_bank(), q.mem_addr[7:0]}] = wb;
                end else if (q.mem_addr >= bdm_pkg::DISPLAY_BASE) begin
                    disp_img[disp_slot(q.mem_addr)] = wb;
                    r.display_dirty = 1'b1;
                end else begin
                    // status write keeps the stored parity bit
                    if (ri == bdm_pkg::R_PSW)
                        wb[bdm_pkg::PSW_P] = sfr_img[bdm_pkg::R_PSW][bdm_pkg::PSW_P];
                    r.peripheral_hit = ri inside {bdm_pkg::R_T0CON, bdm_pkg::R_T0PRR,
                        bdm_pkg::R_T0LR, bdm_pkg::R_T0HR, bdm_pkg::R_T1CNT, bdm_pkg::R_T1LC,
                        bdm_pkg::R_T1HC, bdm_pkg::R_T1LR, bdm_pkg::R_T1HR, bdm_pkg::R_BTCR,
                        bdm_pkg::R_VTRBF};
                    r.retune_audio = ri inside {bdm_pkg::R_T1CNT, bdm_pkg::R_T1LR,
                        bdm_pkg::R_T1LC};
                    sfr_img[ri] = wb;
                end
            end
            bdm_pkg::REQ_INDIR: begin
                slot = {sfr_img[bdm_pkg::R_PSW][bdm_pkg::PSW_PTRBK_HI],
                        sfr_img[bdm_pkg::R_PSW][bdm_pkg::PSW_PTRBK_LO], q.pointer_sel};
                r.resolved_addr = {q.pointer_sel[1], ram_img[{cur_bank(), 4'h0, slot}]};
            end
            bdm_pkg::REQ_PUSH: begin
                sp = sfr_img[bdm_pkg::R_SP] + 8'd1;
                sfr_img[bdm_pkg::R_SP] = sp;
                ram_img[{1'b0, sp}] = wb;
            end
            bdm_pkg::REQ_POP: begin
                sp = sfr_img[bdm_pkg::R_SP];
                r.read_byte = ram_img[{1'b0, sp}];
                sfr_img[bdm_pkg::R_SP] = sp - 8'd1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic bdm_pkg::t_req mk(logic [bdm_pkg::REQ_W-1:0] rt,
                                         logic [bdm_pkg::ADDR_W-1:0] a,
                                         logic [bdm_pkg::BYTE_W-1:0] wb,
                                         logic [bdm_pkg::PTR_W-1:0] p,
                                         logic [bdm_pkg::BYTE_W-1:0] btn);
        bdm_pkg::t_req q;
        q.req_type      = rt;
        q.mem_addr      = a;
        q.write_byte    = wb;
        q.pointer_sel   = p;
        q.button_levels = btn;
        return q;
    endfunction

    // queue a request behind a random gap, short mostly, sometimes long
    task automatic add_access(bdm_pkg::t_req q, bit settle);
        t_access e;
        int k;
        k = $urandom_range(0, 99);
        e.rq     = q;
        e.settle = settle;
        if (calm || k < 50) e.idle = 0;
        else if (k < 90)    e.idle = $urandom_range(1, 3);
        else                e.idle = $urandom_range(10, 40);
        access_q.push_back(e);
    endtask

    // random request aimed at named registers, low ram and display
    function automatic bdm_pkg::t_req rand_access();
        bdm_pkg::t_req q;
        int k;
        q.write_byte    = 8'($urandom);
        q.pointer_sel   = 2'($urandom);
        q.button_levels = 8'($urandom);
        k = $urandom_range(0, 99);
        if (k < 28)      q.req_type = bdm_pkg::REQ_READ;
        else if (k < 58) q.req_type = bdm_pkg::REQ_WRITE;
        else if (k < 68) q.req_type = bdm_pkg::REQ_INDIR;
        else if (k < 79) q.req_type = bdm_pkg::REQ_PUSH;
        else if (k < 90) q.req_type = bdm_pkg::REQ_POP;
        else             q.req_type = 3'($urandom);
        case ($urandom_range(0, 3))
            0:       q.mem_addr = bdm_pkg::SFR_LOW |
                                  bdm_pkg::ADDR_W'(named_regs[$urandom_range(0, 17)]);
            1:       q.mem_addr = bdm_pkg::ADDR_W'($urandom_range(0, 31));
            2:       q.mem_addr = bdm_pkg::ADDR_W'($urandom_range(
                                      int'(bdm_pkg::DISPLAY_BASE), 511));
            default: q.mem_addr = bdm_pkg::ADDR_W'($urandom);
        endcase
        return q;
    endfunction

    // stimulus, reset and end of run
    initial begin
        foreach (ram_img[i])  ram_img[i]  = '0;
        foreach (sfr_img[i])  sfr_img[i]  = '0;
        foreach (disp_img[i]) disp_img[i] = '0;

        // parity on status read, parity bit kept on status write
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_ACC, 8'h07, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ, bdm_pkg::SFR_LOW | bdm_pkg::R_PSW, 8'h00, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_PSW, 8'hFE, 2'd0,
                      8'h00), 1'b0);
        // indirect through the top pointer bank in ram bank 1
        add_access(mk(bdm_pkg::REQ_WRITE, 9'h00F, 8'hAB, 2'd0, 8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_INDIR, 9'h000, 8'h00, 2'd3, 8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ,  9'h0FF, 8'h00, 2'd0, 8'h00), 1'b0);
        // buttons read back inverted
        add_access(mk(bdm_pkg::REQ_READ, bdm_pkg::SFR_LOW | bdm_pkg::R_P3, 8'h00, 2'd0,
                      8'hA5), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_P3, 8'h3C, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ, bdm_pkg::SFR_LOW | bdm_pkg::R_P3, 8'h00, 2'd0,
                      8'hFF), 1'b0);
        // display bank 3 clamps to bank 2
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_XBNK, 8'h03, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, 9'h1FF, 8'h55, 2'd0, 8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_XBNK, 8'h02, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ,  9'h1FF, 8'h00, 2'd0, 8'h00), 1'b0);
        // timer and transfer registers
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_T1CNT, 8'hFF, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ, bdm_pkg::SFR_LOW | bdm_pkg::R_T0L, 8'h00, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_VTRBF, 8'h80, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_READ, bdm_pkg::SFR_LOW | bdm_pkg::R_VTRBF, 8'h00, 2'd0,
                      8'h00), 1'b0);
        // stack pointer wraps both ways
        add_access(mk(bdm_pkg::REQ_POP,  9'h000, 8'h00, 2'd0, 8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_PUSH, 9'h000, 8'h81, 2'd0, 8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_POP,  9'h000, 8'h00, 2'd0, 8'h00), 1'b0);
        // unknown request codes
        add_access(mk(3'd5, 9'h1FF, 8'hFF, 2'd3, 8'hFF), 1'b0);
        add_access(mk(3'd6, 9'h1FF, 8'hFF, 2'd3, 8'hFF), 1'b0);
        add_access(mk(3'd7, 9'h1FF, 8'hFF, 2'd3, 8'hFF), 1'b0);
        add_access(mk(bdm_pkg::REQ_WRITE, bdm_pkg::SFR_LOW | bdm_pkg::R_PSW, 8'h00, 2'd0,
                      8'h00), 1'b0);
        add_access(mk(bdm_pkg::REQ_INDIR, 9'h000, 8'h00, 2'd0, 8'h00), 1'b1);

        // random part with back-to-back stretches and periodic drains
        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i % 400) < 60;
            add_access(rand_access(), (i % 250) == 249);
        end
        n_total = access_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_taken == n_total);
        wait (access_due.size() == 0);
        repeat (8) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                access_due.push_back(access_model(i_req));
                n_taken++;
            end
            if (!(start && busy)) begin
                if (access_q.size() == 0) begin
                    start <= 1'b0;
                end else if (access_q[0].idle > 0) begin
                    access_q[0].idle = access_q[0].idle - 1;
                    start <= 1'b0;
                end else if (access_q[0].settle && access_due.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_req <= access_q[0].rq;
                    void'(access_q.pop_front());
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        bdm_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (access_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %h", o_result);
            end else begin
                want = access_due.pop_front();
                if (o_result.read_byte !== want.read_byte ||
                    o_result.resolved_addr !== want.resolved_addr ||
                    o_result.display_dirty !== want.display_dirty ||
                    o_result.peripheral_hit !== want.peripheral_hit ||
                    o_result.retune_audio !== want.retune_audio) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: rd %h/%h addr %h/%h dirty %b/%b hit %b/%b tune %b/%b",
                                 want.read_byte, o_result.read_byte,
                                 want.resolved_addr, o_result.resolved_addr,
                                 want.display_dirty, o_result.display_dirty,
                                 want.peripheral_hit, o_result.peripheral_hit,
                                 want.retune_audio, o_result.retune_audio);
                end
            end
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
